// ===== design/segregated_free_list_first_fit_assert.svh =====
// Assertion macros for the segregated free list allocator.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef SEGREGATED_FREE_LIST_FIRST_FIT_ASSERT_SVH
`define SEGREGATED_FREE_LIST_FIRST_FIT_ASSERT_SVH
`ifndef SYNTHESIS
// Check prop on every rising clock edge outside of reset.
`define SFL_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
		else $error("sfl assertion failed");
// Check prop on every rising clock edge, reset included.
`define SFL_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("sfl assertion failed");
`else
`define SFL_ASSERT(lbl, clk, rstn, prop)
`define SFL_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== design/sfl_pkg.sv =====
// Shared types and constants of the segregated free list allocator.
// No dependencies; used by sfl_cell, sfl_chain and the top level.
package sfl_pkg;

	localparam int LIST_ENTRIES_DEF = 16;
	localparam int SIZE_BITS_DEF    = 16;
	localparam int FIELD_SIZE_BITS  = 16;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_NOFIT = 2'd2
	} status_t;

	typedef enum logic {
		KIND_INSERT   = 1'b0,
		KIND_ALLOCATE = 1'b1
	} kind_t;

	typedef enum logic {
		LIST_SMALL = 1'b0,
		LIST_LARGE = 1'b1
	} list_t;

	typedef enum logic [1:0] {
		CH_HOLD = 2'd0,
		CH_PUSH = 2'd1,
		CH_PULL = 2'd2
	} chain_op_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		chain_op_t op;
	} chain_ctl_t;

	typedef struct packed {
		logic full;
		logic hit;
	} chain_stat_t;

endpackage

// ===== design/sfl_cell.sv =====
// One cell of a free list: holds one block size and hands it to a neighbor.
// Depends on sfl_pkg for the chain operation codes.
module sfl_cell #(
	parameter int SIZE_BITS = sfl_pkg::SIZE_BITS_DEF
) (
	input  logic                  clk,
	input  sfl_pkg::chain_op_t    op,
	input  logic                  valid,
	input  logic [SIZE_BITS-1:0]  req,
	input  logic [SIZE_BITS-1:0]  prev_size,
	input  logic [SIZE_BITS-1:0]  next_size,
	input  logic                  found_in,
	input  logic [SIZE_BITS-1:0]  grant_in,
	output logic                  found_out,
	output logic [SIZE_BITS-1:0]  grant_out,
	output logic [SIZE_BITS-1:0]  size_out
);

	logic [SIZE_BITS-1:0] size_q;
	logic                 hit;

	assign hit       = valid && (size_q >= req);
	assign found_out = found_in || hit;
	// first hit from the head wins
	assign grant_out = (!found_in && hit) ? size_q : grant_in;
	assign size_out  = size_q;

	always_ff @(posedge clk) begin
		case (op)
			sfl_pkg::CH_PUSH: size_q <= prev_size;
			sfl_pkg::CH_PULL: begin
				// close the gap at and behind the hit
				if (found_out) begin
					size_q <= next_size;
				end
			end
			default: size_q <= size_q;
		endcase
	end

endmodule

// ===== design/sfl_chain.sv =====
// One bounded free list built as a row of sfl_cell with a fill count.
// Depends on sfl_pkg and sfl_cell.
module sfl_chain #(
	parameter int LIST_ENTRIES = sfl_pkg::LIST_ENTRIES_DEF,
	parameter int SIZE_BITS    = sfl_pkg::SIZE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sfl_pkg::chain_ctl_t   ctl,
	input  logic [SIZE_BITS-1:0]  req,
	input  logic [SIZE_BITS-1:0]  new_size,
	output sfl_pkg::chain_stat_t  stat,
	output logic [SIZE_BITS-1:0]  grant
);

	localparam int CNT_W = $clog2(LIST_ENTRIES + 1);

	logic [CNT_W-1:0]     count_q;
	logic [SIZE_BITS-1:0] size_w  [LIST_ENTRIES];
	logic [SIZE_BITS-1:0] prev_w  [LIST_ENTRIES];
	logic [SIZE_BITS-1:0] next_w  [LIST_ENTRIES];
	logic [SIZE_BITS-1:0] grant_w [LIST_ENTRIES+1];
	logic                 found_w [LIST_ENTRIES+1];

	assign found_w[0] = 1'b0;
	assign grant_w[0] = '0;

	for (genvar i = 0; i < LIST_ENTRIES; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign prev_w[i] = new_size;
		end else begin : g_body
			assign prev_w[i] = size_w[i-1];
		end
		if (i == LIST_ENTRIES - 1) begin : g_tail
			assign next_w[i] = size_w[i];
		end else begin : g_inner
			assign next_w[i] = size_w[i+1];
		end

		sfl_cell #(
			.SIZE_BITS (SIZE_BITS)
		) u_cell (
			.clk       (clk),
			.op        (ctl.op),
			.valid     (count_q > CNT_W'(i)),
			.req       (req),
			.prev_size (prev_w[i]),
			.next_size (next_w[i]),
			.found_in  (found_w[i]),
			.grant_in  (grant_w[i]),
			.found_out (found_w[i+1]),
			.grant_out (grant_w[i+1]),
			.size_out  (size_w[i])
		);
	end

	assign stat.full = (count_q == CNT_W'(LIST_ENTRIES));
	assign stat.hit  = found_w[LIST_ENTRIES];
	assign grant     = grant_w[LIST_ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (ctl.op)
				sfl_pkg::CH_PUSH: count_q <= count_q + CNT_W'(1);
				sfl_pkg::CH_PULL: count_q <= count_q - CNT_W'(1);
				default:          count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/segregated_free_list_first_fit.sv =====
// Segregated free list allocator, first fit over a small and a large list.
// Each transaction is captured, then makes one pass through both cell rows (compare,
// first-hit ripple, shift); no new item is taken until the last result is registered.
// The result sits in an output register; the next item is taken while it waits.
// Asynchronous active-low reset empties both lists; size cells are not cleared.
// Depends on sfl_pkg, sfl_chain, sfl_cell and segregated_free_list_first_fit_assert.svh.
`include "segregated_free_list_first_fit_assert.svh"

module segregated_free_list_first_fit #(
	parameter int LIST_ENTRIES = sfl_pkg::LIST_ENTRIES_DEF,
	parameter int SIZE_BITS    = sfl_pkg::SIZE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic        list_select,
	input  logic [15:0] block_size,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] granted_size,
	output logic        source_list
);

	localparam int FB = sfl_pkg::FIELD_SIZE_BITS;

	sfl_pkg::state_t      state_q, state_d;
	sfl_pkg::kind_t       kind_q;
	sfl_pkg::list_t       sel_q;
	logic [SIZE_BITS-1:0] req_q;

	sfl_pkg::chain_ctl_t  ctl_small, ctl_large;
	sfl_pkg::chain_stat_t stat_small, stat_large;
	logic [SIZE_BITS-1:0] grant_small, grant_large;

	logic                 accept;
	logic                 exec_go;
	sfl_pkg::status_t     status_d, status_q;
	logic [SIZE_BITS-1:0] grant_d;
	logic                 source_d;
	logic [FB-1:0]        grant_q;
	logic                 source_q;
	logic                 out_valid_q;

	assign accept = in_valid && !in_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sfl_pkg::ST_IDLE: if (accept) state_d = sfl_pkg::ST_EXEC;
			sfl_pkg::ST_EXEC: if (exec_go) state_d = sfl_pkg::ST_IDLE;
			default:          state_d = sfl_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall = 1'b1;
		exec_go  = 1'b0;
		case (state_q)
			sfl_pkg::ST_IDLE: in_stall = 1'b0;
			sfl_pkg::ST_EXEC: exec_go = !out_valid_q || !out_stall;
			default:          in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= sfl_pkg::kind_t'(kind);
			sel_q  <= sfl_pkg::list_t'(list_select);
			req_q  <= SIZE_BITS'(block_size);
		end
	end

	// pick list operations and the result
	always_comb begin
		ctl_small.op = sfl_pkg::CH_HOLD;
		ctl_large.op = sfl_pkg::CH_HOLD;
		status_d     = sfl_pkg::STAT_OK;
		grant_d      = '0;
		source_d     = 1'b0;
		if (kind_q == sfl_pkg::KIND_INSERT) begin
			if (sel_q == sfl_pkg::LIST_SMALL) begin
				if (stat_small.full) begin
					status_d = sfl_pkg::STAT_FULL;
				end else begin
					ctl_small.op = sfl_pkg::CH_PUSH;
				end
			end else begin
				if (stat_large.full) begin
					status_d = sfl_pkg::STAT_FULL;
				end else begin
					ctl_large.op = sfl_pkg::CH_PUSH;
				end
			end
		end else begin
			if (stat_small.hit) begin
				ctl_small.op = sfl_pkg::CH_PULL;
				grant_d      = grant_small;
			end else if (stat_large.hit) begin
				ctl_large.op = sfl_pkg::CH_PULL;
				grant_d      = grant_large;
				source_d     = 1'b1;
			end else begin
				status_d = sfl_pkg::STAT_NOFIT;
			end
		end
		// touch the lists only on the cycle the result is written
		if (!exec_go) begin
			ctl_small.op = sfl_pkg::CH_HOLD;
			ctl_large.op = sfl_pkg::CH_HOLD;
		end
	end

	sfl_chain #(
		.LIST_ENTRIES (LIST_ENTRIES),
		.SIZE_BITS    (SIZE_BITS)
	) u_small (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_small),
		.req      (req_q),
		.new_size (req_q),
		.stat     (stat_small),
		.grant    (grant_small)
	);

	sfl_chain #(
		.LIST_ENTRIES (LIST_ENTRIES),
		.SIZE_BITS    (SIZE_BITS)
	) u_large (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_large),
		.req      (req_q),
		.new_size (req_q),
		.stat     (stat_large),
		.grant    (grant_large)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			status_q <= status_d;
			grant_q  <= FB'(grant_d);
			source_q <= source_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign granted_size = grant_q;
	assign source_list  = source_q;

	`SFL_ASSERT(a_accept_busy, clk, arst_n, accept |=> in_stall)
	`SFL_ASSERT(a_push_not_full, clk, arst_n, (ctl_small.op == sfl_pkg::CH_PUSH) |-> !stat_small.full)
	`SFL_ASSERT(a_pull_on_hit, clk, arst_n, (ctl_large.op == sfl_pkg::CH_PULL) |-> (stat_large.hit && !stat_small.hit))
	`SFL_ASSERT(a_fail_no_grant, clk, arst_n, (out_valid && status != sfl_pkg::STAT_OK) |-> (granted_size == '0 && !source_list))

endmodule

// ===== bench/tb_segregated_free_list_first_fit.sv =====
// Testbench for segregated_free_list_first_fit: a directed table, then random insert/allocate
// traffic with random idling on both channels, each result checked against the table or a local list model.
// Depends on sfl_pkg and the RTL of the block only.
module tb_segregated_free_list_first_fit;
	timeunit 1ns;
	timeprecision 1ps;

	import sfl_pkg::*;

	localparam int ENTRIES = LIST_ENTRIES_DEF;
	localparam int unsigned SIZE_MASK_W =
		(SIZE_BITS_DEF >= 32) ? 32'hFFFF_FFFF : ((32'd1 << SIZE_BITS_DEF) - 1);
	localparam logic [15:0] SIZE_MASK = SIZE_MASK_W[15:0];
	localparam int RANDOM_ITEMS = 1525;
	localparam int HOLD_CYCLES = 200;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		status_t     status;
		logic [15:0] granted;
		list_t       source;
	} grant_t;

	typedef struct packed {
		kind_t       kind;
		list_t       sel;
		logic [15:0] size;
		logic [4:0]  reps;
		logic        typed;
		grant_t      want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        kind = 1'b0;
	logic        list_select = 1'b0;
	logic [15:0] block_size = 16'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [15:0] granted_size;
	logic        source_list;

	// free list model: entry 0 is the head
	logic [15:0] cells [2][ENTRIES];
	int unsigned fill [2];

	grant_t pending_grants [$];
	int mismatches = 0;
	int accepted = 0;
	int retired = 0;
	int quiet_left = 0;
	int cycles = 0;
	bit hold_req = 1'b0;

	segregated_free_list_first_fit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.list_select (list_select),
		.block_size  (block_size),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.granted_size(granted_size),
		.source_list (source_list)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic grant_t allocate_or_insert(kind_t k, list_t sel, logic [15:0] raw);
		grant_t g;
		logic [15:0] sz;
		int i;
		int j;
		int li;
		bit hit;
		g = '{STAT_OK, 16'd0, LIST_SMALL};
		sz = raw & SIZE_MASK;
		hit = 1'b0;
		if (k == KIND_INSERT) begin
			li = (sel == LIST_LARGE) ? 1 : 0;
			if (fill[li] >= ENTRIES) begin
				g.status = STAT_FULL;
			end else begin
				for (i = fill[li]; i > 0; i--)
					cells[li][i] = cells[li][i - 1];
				cells[li][0] = sz;
				fill[li]++;
			end
		end else begin
			// small list first, then fall back to the large one
			for (li = 0; li < 2; li++) begin
				for (i = 0; i < fill[li]; i++) begin
					if (!hit && cells[li][i] >= sz) begin
						hit = 1'b1;
						g.granted = cells[li][i];
						g.source = list_t'(li);
						for (j = i; j + 1 < fill[li]; j++)
							cells[li][j] = cells[li][j + 1];
						fill[li]--;
					end
				end
			end
			if (!hit)
				g.status = STAT_NOFIT;
		end
		return g;
	endfunction

	function automatic stim_row_t plan_row(kind_t k, list_t sel, logic [15:0] sz, int reps,
			bit typed, status_t st, logic [15:0] gs, list_t src);
		stim_row_t r;
		r.kind = k;
		r.sel = sel;
		r.size = sz;
		r.reps = reps[4:0];
		r.typed = typed;
		r.want = '{st, gs, src};
		return r;
	endfunction

	task automatic flag_mismatch(string what, int got, int want);
		$display("mismatch on result %0d: %s got %0d want %0d", retired, what, got, want);
		mismatches++;
	endtask

	task automatic offer(kind_t k, list_t sel, logic [15:0] sz, bit typed, grant_t want);
		grant_t pred;
		int gap;
		int r;
		@(negedge clk);
		in_valid <= 1'b1;
		kind <= k;
		list_select <= sel;
		block_size <= sz;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pred = allocate_or_insert(k, sel, sz);
		pending_grants.push_back(typed ? want : pred);
		accepted++;
		if (quiet_left > 0) begin
			quiet_left--;
			gap = 0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 55)
				gap = 0;
			else if (r < 90)
				gap = $urandom_range(1, 3);
			else if (r < 97)
				gap = $urandom_range(4, 12);
			else
				gap = $urandom_range(20, 60);
			if ($urandom_range(0, 49) == 0)
				quiet_left = $urandom_range(20, 80);
		end
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// result side: check every accepted transaction against the oldest expectation
	always @(posedge clk) begin
		grant_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_grants.size() == 0) begin
				flag_mismatch("result with nothing pending, granted_size", granted_size, 0);
			end else begin
				want = pending_grants.pop_front();
				if (status !== want.status)
					flag_mismatch("status", status, want.status);
				if (granted_size !== want.granted)
					flag_mismatch("granted_size", granted_size, want.granted);
				if (source_list !== want.source)
					flag_mismatch("source_list", source_list, want.source);
			end
			retired++;
		end
	end

	// receiver: random stall runs, quiet stretches, and one long hold-off on request
	initial begin : receiver
		int r;
		int busy;
		int idle;
		bit held;
		held = 1'b0;
		forever begin
			if (hold_req && !held) begin
				held = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk) out_stall <= 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 65)
				busy = 0;
			else if (r < 92)
				busy = $urandom_range(1, 3);
			else
				busy = $urandom_range(8, 40);
			idle = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 6);
			repeat (busy) @(negedge clk) out_stall <= 1'b1;
			repeat (idle) @(negedge clk) out_stall <= 1'b0;
		end
	end

	initial begin : stimulus
		stim_row_t directed_plan [$];
		stim_row_t row;
		grant_t none;
		kind_t k;
		list_t sel;
		logic [15:0] sz;
		int n;
		int rep;
		int burst_left;
		int insert_pct;
		int r;
		int li;
		int idx;
		none = '{STAT_OK, 16'd0, LIST_SMALL};
		fill[0] = 0;
		fill[1] = 0;

		// kind, list, size, repeats, typed, expected status / granted / source
		directed_plan.push_back(plan_row(KIND_ALLOCATE, LIST_SMALL, 16'h0000, 1, 1,
			STAT_NOFIT, 16'd0, LIST_SMALL));
		directed_plan.push_back(plan_row(KIND_ALLOCATE, LIST_LARGE, 16'hFFFF, 1, 1,
			STAT_NOFIT, 16'd0, LIST_SMALL));
		directed_plan.push_back(plan_row(KIND_INSERT, LIST_LARGE, 16'hFFFF, 1, 1,
			STAT_OK, 16'd0, LIST_SMALL));
		directed_plan.push_back(plan_row(KIND_ALLOCATE, LIST_SMALL, 16'hFFFF, 1, 0,
			STAT_OK, 16'd0, LIST_SMALL));
		directed_plan.push_back(plan_row(KIND_INSERT, LIST_SMALL, 16'h0000, 1, 1,
			STAT_OK, 16'd0, LIST_SMALL));
		directed_plan.push_back(plan_row(KIND_ALLOCATE, LIST_LARGE, 16'h0000, 1, 0,
			STAT_OK, 16'd0, LIST_SMALL));
		directed_plan.push_back(plan_row(KIND_INSERT, LIST_SMALL, 16'h0100, 16, 1,
			STAT_OK, 16'd0, LIST_SMALL));
		directed_plan.push_back(plan_row(KIND_INSERT, LIST_SMALL, 16'hFFFF, 1, 1,
			STAT_FULL, 16'd0, LIST_SMALL));
		directed_plan.push_back(plan_row(KIND_INSERT, LIST_LARGE, 16'h0001, 1, 1,
			STAT_OK, 16'd0, LIST_SMALL));
		directed_plan.push_back(plan_row(KIND_ALLOCATE, LIST_SMALL, 16'h0108, 1, 0,
			STAT_OK, 16'd0, LIST_SMALL));
		directed_plan.push_back(plan_row(KIND_ALLOCATE, LIST_SMALL, 16'h0110, 1, 0,
			STAT_OK, 16'd0, LIST_SMALL));
		directed_plan.push_back(plan_row(KIND_ALLOCATE, LIST_LARGE, 16'h0001, 1, 0,
			STAT_OK, 16'd0, LIST_SMALL));

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_plan[i]) begin
			row = directed_plan[i];
			// repeated rows step the size so the list holds distinct entries
			for (rep = 0; rep < row.reps; rep++)
				offer(row.kind, row.sel, row.size + 16'(rep), row.typed, row.want);
		end

		burst_left = 0;
		insert_pct = 50;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 300)
				hold_req = 1'b1;
			// bursts lean toward filling, balancing or draining the lists
			if (burst_left == 0) begin
				burst_left = $urandom_range(20, 80);
				r = $urandom_range(0, 2);
				insert_pct = (r == 0) ? 85 : (r == 1) ? 50 : 20;
			end
			burst_left--;
			k = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_ALLOCATE;
			sel = list_t'($urandom_range(0, 1));
			r = $urandom_range(0, 99);
			if (k == KIND_INSERT) begin
				if (r < 12)
					sz = 16'h0000;
				else if (r < 24)
					sz = 16'hFFFF;
				else if (r < 50)
					sz = 16'($urandom_range(0, 255));
				else
					sz = 16'($urandom_range(0, 65535));
			end else begin
				if (r < 50 && fill[0] + fill[1] > 0) begin
					li = (fill[0] == 0) ? 1 : (fill[1] == 0) ? 0 : $urandom_range(0, 1);
					idx = $urandom_range(0, fill[li] - 1);
					sz = cells[li][idx] + 16'($urandom_range(0, 1));
				end else if (r < 62) begin
					sz = 16'h0000;
				end else if (r < 74) begin
					sz = 16'hFFFF;
				end else begin
					sz = 16'($urandom_range(0, 65535));
				end
			end
			offer(k, sel, sz, 1'b0, none);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
